// File: sv/sha256md_pkg.sv
package sha256md_pkg;

    typedef logic [31:0] word_t;

    localparam word_t RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic shift_sched;
        logic shift_work;
        logic round;
    } cmp_ctrl_t;

    function automatic word_t ror32(word_t v, int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

// File: sv/sha256md_compress.sv
module sha256md_compress
    import sha256md_pkg::*;
(
    input  logic      clk,
    input  cmp_ctrl_t ctrl,
    input  word_t     sched_in,
    input  word_t     work_in,
    input  logic [5:0] round_idx,
    output word_t     work_head
);

    word_t work_reg  [8];
    word_t sched_reg [16];

    word_t sig_e;
    word_t sig_a;
    word_t ch;
    word_t maj;
    word_t t1;
    word_t t2;
    word_t sig_lo;
    word_t sig_hi;
    word_t sched_new;

    always_comb
    begin
        sig_e = ror32(work_reg[4], 6) ^ ror32(work_reg[4], 11) ^ ror32(work_reg[4], 25);
        ch    = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        t1    = work_reg[7] + sig_e + ch + RoundK[round_idx] + sched_reg[0];
        sig_a = ror32(work_reg[0], 2) ^ ror32(work_reg[0], 13) ^ ror32(work_reg[0], 22);
        maj   = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
              ^ (work_reg[1] & work_reg[2]);
        t2    = sig_a + maj;
        sig_lo = ror32(sched_reg[1], 7) ^ ror32(sched_reg[1], 18) ^ (sched_reg[1] >> 3);
        sig_hi = ror32(sched_reg[14], 17) ^ ror32(sched_reg[14], 19) ^ (sched_reg[14] >> 10);
        sched_new = sched_reg[0] + sig_lo + sched_reg[9] + sig_hi;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.round)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
        else if (ctrl.shift_work)
        begin
            for (int i = 0; i < 7; i++)
            begin
                work_reg[i] <= work_reg[i + 1];
            end
            work_reg[7] <= work_in;
        end

        if (ctrl.round || ctrl.shift_sched)
        begin
            for (int i = 0; i < 15; i++)
            begin
                sched_reg[i] <= sched_reg[i + 1];
            end
            sched_reg[15] <= ctrl.round ? sched_new : sched_in;
        end
    end

    assign work_head = work_reg[0];

endmodule

// File: sv/sha256_message_digest_top.sv
// SHA-256 over a byte stream: one message byte per input word, the end-of-message mark
// closing the message (an end word without a byte is allowed, so empty messages hash).
// Bytes are taken while the block is idle. Each filled 64-byte block is then
// compressed with the input stalled: the block memory and chaining memory are
// streamed into the round unit, 64 rounds run at one per cycle, and the working
// variables are folded back into the chaining memory. On the end word the block pads
// and compresses one or two blocks, then emits the eight digest words, first word
// first, each read from the chaining memory and held until the output is ready. The
// chaining value returns to the initial vector after the eighth word is taken.
module sha256_message_digest_top
    import sha256md_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        digest_valid,
    input  logic        digest_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_number,
    output logic        last_word
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PAD    = 4'd1;
    localparam logic [3:0] S_ZERO   = 4'd2;
    localparam logic [3:0] S_LEN_HI = 4'd3;
    localparam logic [3:0] S_LEN_LO = 4'd4;
    localparam logic [3:0] S_LOAD   = 4'd5;
    localparam logic [3:0] S_ROUND  = 4'd6;
    localparam logic [3:0] S_FOLD   = 4'd7;
    localparam logic [3:0] S_OUT_RD = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    localparam logic [1:0] RET_IDLE = 2'd0;
    localparam logic [1:0] RET_PAD  = 2'd1;
    localparam logic [1:0] RET_ZERO = 2'd2;
    localparam logic [1:0] RET_OUT  = 2'd3;

    localparam logic [4:0] ZeroLimFull = 5'd16;
    localparam logic [4:0] ZeroLimLen  = 5'd14;
    localparam logic [3:0] LenHiAddr   = 4'd14;
    localparam logic [3:0] LenLoAddr   = 4'd15;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  ret_reg, ret_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [4:0]  zcnt_reg, zcnt_next;
    logic        zero_full_reg, zero_full_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] byte_count_reg, byte_count_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic [7:0]  chain_vld_reg, chain_vld_next;
    logic        chain_rvld_reg;
    logic [2:0]  chain_ridx_reg;
    word_t       acc_reg, acc_next;

    word_t block_mem [16];
    word_t chain_mem [8];
    word_t blk_rdata_reg;
    word_t chain_rdata_reg;

    logic       blk_we;
    logic [3:0] blk_waddr;
    word_t      blk_wdata;
    logic       blk_re;
    logic [3:0] blk_raddr;
    logic       chain_re;
    logic [2:0] chain_raddr;
    logic       chain_we;
    word_t      chain_rd;
    word_t      work_head;
    cmp_ctrl_t  ctrl;

    logic [4:0] byte_shift;
    word_t      byte_word;
    word_t      pad_word;
    logic [4:0] zero_lim;

    assign chain_rd   = chain_rvld_reg ? chain_rdata_reg : InitHash[chain_ridx_reg];
    assign byte_shift = {~fill_reg[1:0], 3'b000};
    assign byte_word  = (fill_reg[1:0] == 2'd0)
                      ? (word_t'(data_byte) << byte_shift)
                      : (acc_reg | (word_t'(data_byte) << byte_shift));
    assign pad_word   = (fill_reg[1:0] == 2'd0)
                      ? (word_t'(8'h80) << byte_shift)
                      : (acc_reg | (word_t'(8'h80) << byte_shift));
    assign zero_lim   = zero_full_reg ? ZeroLimFull : ZeroLimLen;

    assign digest_word = chain_rd;
    assign word_number = out_idx_reg;
    assign last_word   = (out_idx_reg == 3'd7);

    sha256md_compress u_compress (
        .clk       (clk),
        .ctrl      (ctrl),
        .sched_in  (blk_rdata_reg),
        .work_in   (chain_rd),
        .round_idx (rnd_reg),
        .work_head (work_head)
    );

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        cnt_next        = cnt_reg;
        rnd_next        = rnd_reg;
        zcnt_next       = zcnt_reg;
        zero_full_next  = zero_full_reg;
        fill_next       = fill_reg;
        byte_count_next = byte_count_reg;
        out_idx_next    = out_idx_reg;
        chain_vld_next  = chain_vld_reg;
        acc_next        = acc_reg;
        blk_we          = 1'b0;
        blk_waddr       = fill_reg[5:2];
        blk_wdata       = '0;
        blk_re          = 1'b0;
        blk_raddr       = cnt_reg[3:0];
        chain_re        = 1'b0;
        chain_raddr     = cnt_reg[2:0];
        chain_we        = 1'b0;
        ctrl            = '0;
        msg_ready       = 1'b0;
        digest_valid    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                msg_ready = 1'b1;
                if (msg_valid)
                begin
                    if (byte_present)
                    begin
                        blk_we          = 1'b1;
                        blk_wdata       = byte_word;
                        acc_next        = byte_word;
                        byte_count_next = byte_count_reg + 61'd1;
                        fill_next       = fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                        begin
                            state_next = S_LOAD;
                            cnt_next   = '0;
                            ret_next   = end_of_message ? RET_PAD : RET_IDLE;
                        end
                        else if (end_of_message)
                        begin
                            state_next = S_PAD;
                        end
                    end
                    else if (end_of_message)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                blk_we         = 1'b1;
                blk_wdata      = pad_word;
                zcnt_next      = {1'b0, fill_reg[5:2]} + 5'd1;
                zero_full_next = (fill_reg[5:3] == 3'b111);
                state_next     = S_ZERO;
            end
            S_ZERO:
            begin
                if (zcnt_reg < zero_lim)
                begin
                    blk_we    = 1'b1;
                    blk_waddr = zcnt_reg[3:0];
                    zcnt_next = zcnt_reg + 5'd1;
                end
                else if (zero_full_reg)
                begin
                    state_next = S_LOAD;
                    cnt_next   = '0;
                    ret_next   = RET_ZERO;
                end
                else
                begin
                    state_next = S_LEN_HI;
                end
            end
            S_LEN_HI:
            begin
                blk_we     = 1'b1;
                blk_waddr  = LenHiAddr;
                blk_wdata  = byte_count_reg[60:29];
                state_next = S_LEN_LO;
            end
            S_LEN_LO:
            begin
                blk_we          = 1'b1;
                blk_waddr       = LenLoAddr;
                blk_wdata       = {byte_count_reg[28:0], 3'b000};
                byte_count_next = '0;
                fill_next       = '0;
                state_next      = S_LOAD;
                cnt_next        = '0;
                ret_next        = RET_OUT;
            end
            S_LOAD:
            begin
                blk_re           = ~cnt_reg[4];
                chain_re         = (cnt_reg < 5'd8);
                ctrl.shift_sched = (cnt_reg != 5'd0);
                ctrl.shift_work  = (cnt_reg != 5'd0) && (cnt_reg <= 5'd8);
                cnt_next         = cnt_reg + 5'd1;
                if (cnt_reg == 5'd16)
                begin
                    state_next = S_ROUND;
                    rnd_next   = '0;
                end
            end
            S_ROUND:
            begin
                ctrl.round = 1'b1;
                rnd_next   = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = S_FOLD;
                    cnt_next   = '0;
                end
            end
            S_FOLD:
            begin
                chain_re = (cnt_reg < 5'd8);
                if (cnt_reg != 5'd0)
                begin
                    chain_we                       = 1'b1;
                    ctrl.shift_work                = 1'b1;
                    chain_vld_next[chain_ridx_reg] = 1'b1;
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd8)
                begin
                    case (ret_reg)
                        RET_IDLE:
                        begin
                            state_next = S_IDLE;
                        end
                        RET_PAD:
                        begin
                            state_next = S_PAD;
                        end
                        RET_ZERO:
                        begin
                            state_next     = S_ZERO;
                            zcnt_next      = '0;
                            zero_full_next = 1'b0;
                        end
                        default:
                        begin
                            state_next   = S_OUT_RD;
                            out_idx_next = '0;
                        end
                    endcase
                end
            end
            S_OUT_RD:
            begin
                chain_re    = 1'b1;
                chain_raddr = out_idx_reg;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                digest_valid = 1'b1;
                if (digest_ready)
                begin
                    if (out_idx_reg == 3'd7)
                    begin
                        chain_vld_next = '0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 3'd1;
                        state_next   = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= RET_IDLE;
            cnt_reg        <= '0;
            rnd_reg        <= '0;
            zcnt_reg       <= '0;
            zero_full_reg  <= 1'b0;
            fill_reg       <= '0;
            byte_count_reg <= '0;
            out_idx_reg    <= '0;
            chain_vld_reg  <= '0;
            chain_rvld_reg <= 1'b0;
            chain_ridx_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            cnt_reg        <= cnt_next;
            rnd_reg        <= rnd_next;
            zcnt_reg       <= zcnt_next;
            zero_full_reg  <= zero_full_next;
            fill_reg       <= fill_next;
            byte_count_reg <= byte_count_next;
            out_idx_reg    <= out_idx_next;
            chain_vld_reg  <= chain_vld_next;
            if (chain_re)
            begin
                chain_rvld_reg <= chain_vld_reg[chain_raddr];
                chain_ridx_reg <= chain_raddr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (blk_we)
        begin
            block_mem[blk_waddr] <= blk_wdata;
        end
        if (blk_re)
        begin
            blk_rdata_reg <= block_mem[blk_raddr];
        end
        if (chain_we)
        begin
            chain_mem[chain_ridx_reg] <= chain_rd + work_head;
        end
        if (chain_re)
        begin
            chain_rdata_reg <= chain_mem[chain_raddr];
        end
    end

endmodule

// File: tb/sv/sha256_message_digest_top_tb.sv
module sha256_message_digest_top_tb;
    import sha256md_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]   dat;
        logic         pres;
        logic         eom;
        logic         typed;
        logic [255:0] digest;
    } stim_row_t;

    typedef struct packed {
        word_t      value;
        logic [2:0] index;
        logic       final_word;
    } digest_out_t;

    localparam logic [255:0] EmptyDigest =
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
    localparam logic [255:0] AbcDigest =
        256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

    localparam int DirectedRows = 14;
    localparam stim_row_t Directed [DirectedRows] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest},
        '{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},
        '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'haa, 1'b0, 1'b0, 1'b0, 256'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1, AbcDigest},
        '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'hff, 1'b0, 1'b1, 1'b0, 256'h0},
        '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
        '{8'h80, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h7f, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h01, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'hfe, 1'b1, 1'b1, 1'b0, 256'h0},
        '{8'h55, 1'b0, 1'b1, 1'b1, EmptyDigest}
    };

    localparam word_t HashStart [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic        clk;
    logic        rst_n = 1'b0;
    logic        msg_valid = 1'b0;
    logic        msg_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        byte_present = 1'b0;
    logic        end_of_message = 1'b0;
    logic        digest_valid;
    logic        digest_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;

    word_t       msg_block [16];
    word_t       chain_hash [8];
    logic [60:0] msg_bytes;
    logic [5:0]  fill_pos;

    digest_out_t pending_words [$];
    int          fail_count = 0;
    int          word_count = 0;
    int          stall_left = 0;
    bit          quiet = 1'b0;

    sha256_message_digest_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .msg_valid      (msg_valid),
        .msg_ready      (msg_ready),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .digest_valid   (digest_valid),
        .digest_ready   (digest_ready),
        .digest_word    (digest_word),
        .word_number    (word_number),
        .last_word      (last_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic word_t rotr(word_t v, int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic void compress_block();
        word_t w [64];
        word_t r [8];
        word_t t1;
        word_t t2;
        for (int i = 0; i < 16; i++)
            w[i] = msg_block[i];
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++)
            r[i] = chain_hash[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25))
               + ((r[4] & r[5]) ^ (~r[4] & r[6])) + RoundConst[i] + w[i];
            t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22))
               + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
            r[7] = r[6];
            r[6] = r[5];
            r[5] = r[4];
            r[4] = r[3] + t1;
            r[3] = r[2];
            r[2] = r[1];
            r[1] = r[0];
            r[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain_hash[i] += r[i];
    endfunction

    function automatic void place_byte(logic [7:0] b);
        int idx;
        int sh;
        idx = int'(fill_pos[5:2]);
        sh = (3 - int'(fill_pos[1:0])) * 8;
        if (fill_pos[1:0] == 2'd0)
            msg_block[idx] = word_t'(b) << sh;
        else
            msg_block[idx] |= word_t'(b) << sh;
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++)
            chain_hash[i] = HashStart[i];
        msg_bytes = '0;
        fill_pos = '0;
    endfunction

    // Advance the hash state by one accepted word; queue the digest on an end mark.
    function automatic void absorb_word(logic [7:0] b, logic p, logic e, logic typed,
                                        logic [255:0] known);
        int nxt;
        logic [63:0] bit_len;
        digest_out_t want;
        if (p)
        begin
            place_byte(b);
            msg_bytes = msg_bytes + 61'd1;
            fill_pos = fill_pos + 6'd1;
            if (fill_pos == 6'd0)
                compress_block();
        end
        if (!e)
            return;
        bit_len = {msg_bytes, 3'b000};
        place_byte(8'h80);
        nxt = int'(fill_pos[5:2]) + 1;
        if (fill_pos >= 6'd56)
        begin
            for (int i = nxt; i < 16; i++)
                msg_block[i] = '0;
            compress_block();
            nxt = 0;
        end
        for (int i = nxt; i < 14; i++)
            msg_block[i] = '0;
        msg_block[14] = bit_len[63:32];
        msg_block[15] = bit_len[31:0];
        compress_block();
        for (int i = 0; i < 8; i++)
        begin
            want.value = typed ? known[255 - 32*i -: 32] : chain_hash[i];
            want.index = 3'(i);
            want.final_word = (i == 7);
            pending_words = {pending_words, want};
        end
        restart_message();
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_word(logic [7:0] b, logic p, logic e, logic typed = 1'b0,
                             logic [255:0] known = '0);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            msg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_valid <= 1'b1;
        data_byte <= b;
        byte_present <= p;
        end_of_message <= e;
        do
            @(posedge clk);
        while (!msg_ready);
        absorb_word(b, p, e, typed, known);
        word_count++;
    endtask

    task automatic drain_digests();
        msg_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_message(int len);
        bit end_on_byte;
        end_on_byte = (len > 0) && $urandom_range(0, 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
            send_word(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte)
            send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            digest_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            digest_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(1, 3);
        end
    end

    always @(posedge clk)
    begin
        digest_out_t want;
        if (rst_n && digest_valid && digest_ready)
        begin
            if (pending_words.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected digest word %h index %0d last %b",
                             digest_word, word_number, last_word);
            end
            else
            begin
                want = pending_words.pop_front();
                if (digest_word !== want.value || word_number !== want.index
                    || last_word !== want.final_word)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("digest word mismatch: want %h/%0d/%b got %h/%0d/%b",
                                 want.value, want.index, want.final_word,
                                 digest_word, word_number, last_word);
                end
            end
        end
    end

    initial
    begin
        int msg_num;
        int long_at;
        int len;
        restart_message();
        for (int i = 0; i < 16; i++)
            msg_block[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DirectedRows; r++)
            send_word(Directed[r].dat, Directed[r].pres, Directed[r].eom,
                      Directed[r].typed, Directed[r].digest);
        drain_digests();

        msg_num = 0;
        long_at = $urandom_range(0, 2);
        while (msg_num <= long_at || word_count < 110)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0)
                drain_digests();
            if (msg_num == long_at)
                len = 70;
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(52, 66);
            else
                len = $urandom_range(0, 12);
            send_message(len);
            msg_num++;
        end
        quiet = 1'b0;
        msg_valid <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending_words.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
